### rtl/core/composite_sync_field_decoder_unit_assert.svh
// Assertion helpers for the composite sync field decoder.
`ifndef COMPOSITE_SYNC_FIELD_DECODER_UNIT_ASSERT_SVH
`define COMPOSITE_SYNC_FIELD_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while in reset.
`define CSFD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csfd assertion failed");

// Next-cycle implication, masked while in reset.
`define CSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csfd assertion failed");

`endif

### rtl/core/csfd_pkg.sv
package csfd_pkg;

   localparam int unsigned PAL_LINES_SHOWN  = 288;
   localparam int unsigned NTSC_LINES_SHOWN = 240;
   localparam int unsigned TOP_LINE         = 15;

   localparam logic [9:0] LINE_MAX       = 10'h3FF;
   localparam logic [9:0] FIRST_VIS_ONE  = 10'(TOP_LINE);
   localparam logic [9:0] FIRST_VIS_TWO  = 10'(TOP_LINE - 1);
   localparam logic [9:0] PAL_LAST_ONE   = 10'(PAL_LINES_SHOWN - 1 + TOP_LINE);
   localparam logic [9:0] PAL_LAST_TWO   = 10'(PAL_LINES_SHOWN - 2 + TOP_LINE);
   localparam logic [9:0] NTSC_LAST_ONE  = 10'(NTSC_LINES_SHOWN - 1 + TOP_LINE);
   localparam logic [9:0] NTSC_LAST_TWO  = 10'(NTSC_LINES_SHOWN - 2 + TOP_LINE);

   localparam logic [7:0] BROAD_PAL  = 8'd5;
   localparam logic [7:0] BROAD_NTSC = 8'd6;
   localparam logic [7:0] BROAD_SAT  = 8'd255;

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_PRE   = 3'd1,
      PH_SYNC  = 3'd2,
      PH_POST  = 3'd3,
      PH_HSYNC = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      VIDEO_UNKNOWN = 2'd0,
      VIDEO_PAL     = 2'd1,
      VIDEO_NTSC    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_VSYNC_HIGH_MIN  = 3'd0,
      CSR_VSYNC_HIGH_MAX  = 3'd1,
      CSR_HSYNC_PRIOR_MIN = 3'd2,
      CSR_SHORT_MIN       = 3'd3,
      CSR_SHORT_MAX       = 3'd4,
      CSR_HSYNC_MAX       = 3'd5,
      CSR_BROAD_MIN       = 3'd6,
      CSR_BROAD_MAX       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] vsync_high_min;
      logic [15:0] vsync_high_max;
      logic [15:0] hsync_prior_min;
      logic [15:0] short_min;
      logic [15:0] short_max;
      logic [15:0] hsync_max;
      logic [15:0] broad_min;
      logic [15:0] broad_max;
   } cfg_type;

   typedef struct packed {
      logic [15:0] last_capture;
      logic [15:0] last_pulse_length;
      phase_type   phase;
      logic        field;
      logic [7:0]  broad_count;
      mode_type    mode;
      logic [9:0]  line;
      logic [9:0]  first_visible;
      logic [9:0]  last_visible;
      logic        next_visible;
      logic [9:0]  visible_count;
      logic [15:0] frame_errors;
      logic [15:0] total_errors;
      logic [15:0] good_frames;
   } state_type;

   typedef struct packed {
      logic [15:0] capture_time;
      logic        edge_is_falling;
   } req_payload_type;

   typedef struct packed {
      logic        line_start;
      logic [9:0]  visible_index;
      logic        fill_request;
      logic [9:0]  fill_line;
      logic        frame_start;
      logic        pulse_error;
      logic [2:0]  sync_phase;
      logic        field_odd;
      logic [1:0]  video_mode;
      logic [9:0]  field_line;
      logic [15:0] valid_frames;
      logic [15:0] error_total;
   } rsp_payload_type;

endpackage

### rtl/core/csfd_stream_if.sv
interface csfd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/csfd_decide.sv
module csfd_decide
   import csfd_pkg::*;
(
   input  state_type       cur,
   input  cfg_type         cfg,
   input  req_payload_type item,
   output state_type       nxt,
   output rsp_payload_type res
);

   logic [15:0] len;
   logic        err;
   logic        line_start;
   logic        fill_req;
   logic [9:0]  fill_line;
   logic        frame_start;

   assign len = item.capture_time - cur.last_capture;

   always_comb begin
      nxt         = cur;
      err         = 1'b0;
      line_start  = 1'b0;
      fill_req    = 1'b0;
      fill_line   = '0;
      frame_start = 1'b0;

      if (item.edge_is_falling) begin
         // half-line high after a real hsync marks the field
         if (len > cfg.vsync_high_min && len < cfg.vsync_high_max &&
             cur.last_pulse_length > cfg.hsync_prior_min) begin
            case (cur.mode)
               VIDEO_PAL:  nxt.field = 1'b1;
               VIDEO_NTSC: nxt.field = 1'b0;
               default:    nxt.phase = PH_WAIT;
            endcase
         end
      end else if (len < cfg.short_min) begin
         err = 1'b1;
      end else if (len < cfg.short_max) begin
         case (cur.phase)
            PH_WAIT: nxt.phase = PH_PRE;
            PH_PRE, PH_POST: ;
            PH_SYNC: begin
               nxt.phase = PH_POST;
               if (cur.broad_count == BROAD_PAL) begin
                  nxt.mode          = VIDEO_PAL;
                  nxt.first_visible = cur.field ? FIRST_VIS_TWO : FIRST_VIS_ONE;
                  nxt.last_visible  = cur.field ? PAL_LAST_TWO : PAL_LAST_ONE;
               end else if (cur.broad_count == BROAD_NTSC) begin
                  nxt.mode          = VIDEO_NTSC;
                  nxt.first_visible = cur.field ? FIRST_VIS_TWO : FIRST_VIS_ONE;
                  nxt.last_visible  = cur.field ? NTSC_LAST_TWO : NTSC_LAST_ONE;
               end
            end
            PH_HSYNC: begin
               nxt.phase = PH_PRE;
               if (cur.field) begin
                  if (cur.frame_errors == '0) begin
                     nxt.good_frames = cur.good_frames + 16'd1;
                  end
                  nxt.frame_errors = '0;
               end
            end
            default: err = 1'b1;
         endcase
      end else if (len < cfg.hsync_max) begin
         if (cur.next_visible) begin
            line_start        = 1'b1;
            nxt.visible_count = cur.visible_count + 10'd1;
         end
         if (cur.phase == PH_POST || cur.phase == PH_HSYNC) begin
            nxt.phase = PH_HSYNC;
            if (cur.line < LINE_MAX) begin
               nxt.line = cur.line + 10'd1;
            end
            nxt.next_visible = (nxt.line >= cur.first_visible) &&
                               (nxt.line <= cur.last_visible);
            if (nxt.next_visible) begin
               fill_req  = 1'b1;
               fill_line = nxt.visible_count;
            end
         end else begin
            err = 1'b1;
         end
      end else if (len >= cfg.broad_min && len <= cfg.broad_max) begin
         if (cur.phase == PH_PRE) begin
            nxt.phase         = PH_SYNC;
            nxt.broad_count   = '0;
            frame_start       = cur.field;
            nxt.field         = ~cur.field;
            nxt.line          = '0;
            nxt.visible_count = '0;
            nxt.next_visible  = 1'b0;
         end
         if (nxt.phase == PH_POST) begin
            nxt.field = 1'b1;
         end
         if (nxt.phase == PH_SYNC && nxt.broad_count < BROAD_SAT) begin
            nxt.broad_count = nxt.broad_count + 8'd1;
         end
      end else begin
         err = 1'b1;
      end

      if (err) begin
         nxt.frame_errors = cur.frame_errors + 16'd1;
         nxt.total_errors = cur.total_errors + 16'd1;
      end

      nxt.last_pulse_length = len;
      nxt.last_capture      = item.capture_time;
   end

   always_comb begin
      res.line_start    = line_start;
      res.visible_index = nxt.visible_count;
      res.fill_request  = fill_req;
      res.fill_line     = fill_line;
      res.frame_start   = frame_start;
      res.pulse_error   = err;
      res.sync_phase    = nxt.phase;
      res.field_odd     = nxt.field;
      res.video_mode    = nxt.mode;
      res.field_line    = nxt.line;
      res.valid_frames  = nxt.good_frames;
      res.error_total   = nxt.total_errors;
   end

endmodule

### rtl/core/composite_sync_field_decoder_unit.sv
// Composite sync field decoder: takes one comparator edge (capture time and
// polarity) per transaction on req_chan and returns exactly one status
// transaction per edge on rsp_chan. Each edge is classified against the csr_
// thresholds as equalizing, hsync, broad or half-line pulse, and the field
// phase, odd/even field, PAL/NTSC mode, line and visible-line counters and
// error counters are updated. Each accepted edge passes through an input register
// and then a result register; an edge is accepted every cycle while the result
// side keeps taking transactions, since the state update between the two
// registers is combinational. Write the csr_ registers only while no
// transaction is in flight.
`include "composite_sync_field_decoder_unit_assert.svh"

module composite_sync_field_decoder_unit
   import csfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   csfd_stream_if.sink          req_chan,
   csfd_stream_if.source        rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_write_data
);

   cfg_type         cfg_ff;
   state_type       state_ff;
   state_type       state_in;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            advance;
   csr_index_type   csr_sel;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;
   assign csr_sel        = csr_index_type'(csr_index);

   csfd_decide u_decide (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .item (in_data_ff),
      .nxt  (state_in),
      .res  (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vsync_high_min  <= 16'd1280;
         cfg_ff.vsync_high_max  <= 16'd2292;
         cfg_ff.hsync_prior_min <= 16'd280;
         cfg_ff.short_min       <= 16'd120;
         cfg_ff.short_max       <= 16'd280;
         cfg_ff.hsync_max       <= 16'd480;
         cfg_ff.broad_min       <= 16'd2000;
         cfg_ff.broad_max       <= 16'd2400;
      end else if (csr_write_enable) begin
         case (csr_sel)
            CSR_VSYNC_HIGH_MIN:  cfg_ff.vsync_high_min  <= csr_write_data;
            CSR_VSYNC_HIGH_MAX:  cfg_ff.vsync_high_max  <= csr_write_data;
            CSR_HSYNC_PRIOR_MIN: cfg_ff.hsync_prior_min <= csr_write_data;
            CSR_SHORT_MIN:       cfg_ff.short_min       <= csr_write_data;
            CSR_SHORT_MAX:       cfg_ff.short_max       <= csr_write_data;
            CSR_HSYNC_MAX:       cfg_ff.hsync_max       <= csr_write_data;
            CSR_BROAD_MIN:       cfg_ff.broad_min       <= csr_write_data;
            CSR_BROAD_MAX:       cfg_ff.broad_max       <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // advance the decoder state only as a transaction moves to the output
         if (advance) begin
            state_ff <= state_in;
         end
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   `CSFD_ASSERT_SAME(a_fill_in_hsync, clock, reset,
      rsp_chan.valid && rsp_chan.payload.fill_request,
      rsp_chan.payload.sync_phase == PH_HSYNC)
   `CSFD_ASSERT_SAME(a_frame_start_sync, clock, reset,
      rsp_chan.valid && rsp_chan.payload.frame_start,
      rsp_chan.payload.sync_phase == PH_SYNC && !rsp_chan.payload.field_odd)
   `CSFD_ASSERT_NEXT(a_held_item_kept, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_data_ff))
   `CSFD_ASSERT_NEXT(a_errors_only_on_error, clock, reset,
      advance && !out_data_in.pulse_error, $stable(state_ff.total_errors))

endmodule

### tb/sv/composite_sync_field_decoder_unit_tb.sv
`timescale 1ns / 1ps

module composite_sync_field_decoder_unit_tb;
   import csfd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;

   localparam cfg_type DEFAULT_THRESHOLDS = '{
      vsync_high_min:  16'd1280,
      vsync_high_max:  16'd2292,
      hsync_prior_min: 16'd280,
      short_min:       16'd120,
      short_max:       16'd280,
      hsync_max:       16'd480,
      broad_min:       16'd2000,
      broad_max:       16'd2400
   };

   typedef logic [15:0] status_fields_type [12];

   class sync_status_scoreboard;
      cfg_type          cfg;
      state_type        st;
      rsp_payload_type  expected_q[$];
      int unsigned      mismatches;
      int unsigned      checked;
      string            field_names[12] = '{
         "line_start", "visible_index", "fill_request", "fill_line", "frame_start",
         "pulse_error", "sync_phase", "field_odd", "video_mode", "field_line",
         "valid_frames", "error_total"
      };

      function new();
         cfg = DEFAULT_THRESHOLDS;
         st = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_VSYNC_HIGH_MIN:  cfg.vsync_high_min = v;
            CSR_VSYNC_HIGH_MAX:  cfg.vsync_high_max = v;
            CSR_HSYNC_PRIOR_MIN: cfg.hsync_prior_min = v;
            CSR_SHORT_MIN:       cfg.short_min = v;
            CSR_SHORT_MAX:       cfg.short_max = v;
            CSR_HSYNC_MAX:       cfg.hsync_max = v;
            CSR_BROAD_MIN:       cfg.broad_min = v;
            CSR_BROAD_MAX:       cfg.broad_max = v;
            default: ;
         endcase
      endfunction

      function logic count_pulse_error();
         st.frame_errors = st.frame_errors + 16'd1;
         st.total_errors = st.total_errors + 16'd1;
         return 1'b1;
      endfunction

      // Advance the decoder state by one edge and queue the status it produces.
      function void note_edge(req_payload_type e);
         logic [15:0]     len;
         int unsigned     shown;
         rsp_payload_type r;
         len = e.capture_time - st.last_capture;
         r = '0;
         if (e.edge_is_falling) begin
            if (len > cfg.vsync_high_min && len < cfg.vsync_high_max &&
                st.last_pulse_length > cfg.hsync_prior_min) begin
               if (st.mode == VIDEO_PAL)
                  st.field = 1'b1;
               else if (st.mode == VIDEO_NTSC)
                  st.field = 1'b0;
               else
                  st.phase = PH_WAIT;
            end
         end else if (len < cfg.short_min) begin
            r.pulse_error = count_pulse_error();
         end else if (len < cfg.short_max) begin
            case (st.phase)
               PH_WAIT: st.phase = PH_PRE;
               PH_PRE, PH_POST: ;
               PH_SYNC: begin
                  st.phase = PH_POST;
                  if (st.broad_count == BROAD_PAL || st.broad_count == BROAD_NTSC) begin
                     st.mode = (st.broad_count == BROAD_PAL) ? VIDEO_PAL : VIDEO_NTSC;
                     shown = (st.broad_count == BROAD_PAL) ? PAL_LINES_SHOWN
                                                           : NTSC_LINES_SHOWN;
                     st.first_visible = 10'(TOP_LINE);
                     st.last_visible = 10'(shown - 1);
                     if (st.field)
                        st.first_visible = st.first_visible - 10'd1;
                     st.last_visible = st.last_visible + st.first_visible;
                  end
               end
               PH_HSYNC: begin
                  st.phase = PH_PRE;
                  if (st.field) begin
                     if (st.frame_errors == 16'd0)
                        st.good_frames = st.good_frames + 16'd1;
                     st.frame_errors = 16'd0;
                  end
               end
               default: r.pulse_error = count_pulse_error();
            endcase
         end else if (len < cfg.hsync_max) begin
            if (st.next_visible) begin
               r.line_start = 1'b1;
               st.visible_count = st.visible_count + 10'd1;
            end
            if (st.phase == PH_POST || st.phase == PH_HSYNC) begin
               st.phase = PH_HSYNC;
               if (st.line != LINE_MAX)
                  st.line = st.line + 10'd1;
               st.next_visible = (st.line >= st.first_visible && st.line <= st.last_visible);
               if (st.next_visible) begin
                  r.fill_request = 1'b1;
                  r.fill_line = st.visible_count;
               end
            end else begin
               r.pulse_error = count_pulse_error();
            end
         end else if (len >= cfg.broad_min && len <= cfg.broad_max) begin
            if (st.phase == PH_PRE) begin
               st.phase = PH_SYNC;
               st.broad_count = 8'd0;
               if (st.field) begin
                  st.field = 1'b0;
                  r.frame_start = 1'b1;
               end else begin
                  st.field = 1'b1;
               end
               st.line = 10'd0;
               st.visible_count = 10'd0;
               st.next_visible = 1'b0;
            end
            if (st.phase == PH_POST)
               st.field = 1'b1;
            if (st.phase == PH_SYNC && st.broad_count != BROAD_SAT)
               st.broad_count = st.broad_count + 8'd1;
         end else begin
            r.pulse_error = count_pulse_error();
         end

         st.last_pulse_length = len;
         st.last_capture = e.capture_time;

         r.visible_index = st.visible_count;
         r.sync_phase = st.phase;
         r.field_odd = st.field;
         r.video_mode = st.mode;
         r.field_line = st.line;
         r.valid_frames = st.good_frames;
         r.error_total = st.total_errors;
         expected_q.push_back(r);
      endfunction

      function status_fields_type split_status(rsp_payload_type r);
         status_fields_type f;
         f[0] = 16'(r.line_start);
         f[1] = 16'(r.visible_index);
         f[2] = 16'(r.fill_request);
         f[3] = 16'(r.fill_line);
         f[4] = 16'(r.frame_start);
         f[5] = 16'(r.pulse_error);
         f[6] = 16'(r.sync_phase);
         f[7] = 16'(r.field_odd);
         f[8] = 16'(r.video_mode);
         f[9] = 16'(r.field_line);
         f[10] = r.valid_frames;
         f[11] = r.error_total;
         return f;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      task check_status(rsp_payload_type got);
         rsp_payload_type   want;
         status_fields_type got_f;
         status_fields_type want_f;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("status %0h arrived with nothing outstanding", got));
         end else begin
            want = expected_q.pop_front();
            got_f = split_status(got);
            want_f = split_status(want);
            for (int i = 0; i < 12; i++) begin
               if (got_f[i] !== want_f[i])
                  report_mismatch($sformatf("status %0d field %s: got %0h, expected %0h",
                                            checked, field_names[i], got_f[i], want_f[i]));
            end
         end
         checked++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   csfd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   csfd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   composite_sync_field_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   sync_status_scoreboard sb = new();

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_left = 0;
   bit          hold_pending = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned edges_sent = 0;
   int unsigned fields_sent = 0;
   int unsigned settings_done = 0;
   logic [15:0] now_stamp = 16'd0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Status side: check each transaction, then pick ready for the next cycle.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_status(rsp_chan.payload);
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [15:0] pick(int unsigned lo, int unsigned hi);
      return (lo >= hi) ? 16'(lo) : 16'($urandom_range(hi, lo));
   endfunction

   task send_edge(logic [15:0] cap, logic falling);
      req_payload_type p;
      p.capture_time = cap;
      p.edge_is_falling = falling;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= p;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sb.note_edge(p);
      edges_sent++;
   endtask

   task send_abs(logic [15:0] cap, logic falling);
      now_stamp = cap;
      send_edge(cap, falling);
   endtask

   task send_rel(logic [15:0] len, logic falling);
      send_abs(now_stamp + len, falling);
   endtask

   // Drop valid and wait for every outstanding status before touching the CSRs.
   task settle();
      req_chan.valid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(csr_index_type idx, logic [15:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task program_thresholds(cfg_type c);
      write_reg(CSR_VSYNC_HIGH_MIN, c.vsync_high_min);
      write_reg(CSR_VSYNC_HIGH_MAX, c.vsync_high_max);
      write_reg(CSR_HSYNC_PRIOR_MIN, c.hsync_prior_min);
      write_reg(CSR_SHORT_MIN, c.short_min);
      write_reg(CSR_SHORT_MAX, c.short_max);
      write_reg(CSR_HSYNC_MAX, c.hsync_max);
      write_reg(CSR_BROAD_MIN, c.broad_min);
      write_reg(CSR_BROAD_MAX, c.broad_max);
      csr_write_enable <= 1'b0;
      settings_done++;
   endtask

   task eq_pulse();
      send_rel(pick(sb.cfg.short_min, sb.cfg.short_max - 1), 1'b0);
      send_rel(pick(sb.cfg.vsync_high_max, sb.cfg.vsync_high_max + 1000), 1'b1);
   endtask

   task broad_pulse();
      send_rel(pick(sb.cfg.broad_min, sb.cfg.broad_max), 1'b0);
      send_rel(pick(100, sb.cfg.vsync_high_min), 1'b1);
   endtask

   // Hsync low pulse; with mark set, a half-line high after it marks the field.
   task line_pulse(bit mark);
      int unsigned lo;
      lo = (sb.cfg.short_max > sb.cfg.hsync_prior_min) ? sb.cfg.short_max
                                                       : sb.cfg.hsync_prior_min + 1;
      send_rel(pick(lo, sb.cfg.hsync_max - 1), 1'b0);
      if (mark)
         send_rel(pick(sb.cfg.vsync_high_min + 1, sb.cfg.vsync_high_max - 1), 1'b1);
      else
         send_rel(pick(sb.cfg.vsync_high_max, sb.cfg.vsync_high_max + 2000), 1'b1);
   endtask

   task send_field(int unsigned broads, int unsigned lines, bit mark);
      repeat ($urandom_range(6, 4)) eq_pulse();
      repeat (broads) broad_pulse();
      repeat ($urandom_range(6, 4)) eq_pulse();
      for (int unsigned i = 0; i < lines; i++)
         line_pulse(mark && i == lines - 1);
      fields_sent++;
   endtask

   task noise_edge();
      if ($urandom_range(1))
         send_rel(16'($urandom_range(65535)), 1'($urandom_range(1)));
      else
         send_rel(16'($urandom_range(3000)), 1'($urandom_range(1)));
   endtask

   // Field with a broad pulse after post-equalizing, hsync before it and
   // an out-of-range low pulse in the middle.
   task broken_field();
      repeat ($urandom_range(4, 1)) eq_pulse();
      repeat ($urandom_range(6, 1)) broad_pulse();
      if ($urandom_range(1))
         line_pulse(1'b0);
      repeat ($urandom_range(3, 1)) eq_pulse();
      broad_pulse();
      repeat ($urandom_range(20, 1)) line_pulse(1'b0);
      send_rel(pick(sb.cfg.hsync_max, sb.cfg.broad_min - 1), 1'b0);
      repeat ($urandom_range(10, 1)) line_pulse($urandom_range(3) == 0);
   endtask

   task run_fields(int unsigned budget);
      int unsigned stop_at;
      int unsigned kind;
      int unsigned broads;
      int unsigned lines;
      stop_at = edges_sent + budget;
      while (edges_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            broads = $urandom_range(99);
            broads = (broads < 45) ? 5 : (broads < 90) ? 6 : $urandom_range(8);
            lines = ($urandom_range(99) < 8) ? $urandom_range(310, 290) : $urandom_range(30, 3);
            send_field(broads, lines, $urandom_range(99) < 60);
         end else if (kind < 87) begin
            broken_field();
         end else begin
            repeat ($urandom_range(4, 1)) noise_edge();
         end
      end
   endtask

   task run_noise(int unsigned count);
      repeat (count) noise_edge();
   endtask

   // Saturate the broad pulse count, then run hsyncs past the end of the
   // visible window; rising edges only, so each edge ends one pulse.
   task long_haul();
      int unsigned lo;
      lo = (sb.cfg.short_max > sb.cfg.hsync_prior_min) ? sb.cfg.short_max
                                                       : sb.cfg.hsync_prior_min + 1;
      send_field(5, 3, 1'b0);
      repeat (5) eq_pulse();
      repeat (258) send_rel(pick(sb.cfg.broad_min, sb.cfg.broad_max), 1'b0);
      repeat (5) eq_pulse();
      repeat (305) send_rel(pick(lo, sb.cfg.hsync_max - 1), 1'b0);
      line_pulse(1'b1);
      fields_sent++;
   endtask

   function automatic cfg_type jittered_thresholds();
      cfg_type c;
      c.vsync_high_min = pick(1000, 1400);
      c.vsync_high_max = pick(2100, 2600);
      c.hsync_prior_min = pick(250, 300);
      c.short_min = pick(60, 150);
      c.short_max = pick(200, 300);
      c.hsync_max = pick(420, 560);
      c.broad_min = pick(1800, 2100);
      c.broad_max = pick(2300, 2700);
      return c;
   endfunction

   function automatic cfg_type corner_thresholds();
      cfg_type c;
      c = '0;
      for (int i = 0; i < 128; i += 16)
         c[i +: 16] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return c;
   endfunction

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_VSYNC_HIGH_MIN;
      csr_write_data <= 16'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 19;
      rsp_idle_pct = 59;

      // Directed edges under reset thresholds.
      send_abs(16'h0000, 1'b0);
      send_abs(16'hFFFF, 1'b1);
      send_rel(16'd200, 1'b0);
      send_rel(16'd1800, 1'b1);
      send_rel(16'd350, 1'b0);
      send_rel(16'd1800, 1'b1);
      send_rel(16'd1000, 1'b0);
      send_rel(16'd300, 1'b1);
      send_rel(16'd2200, 1'b0);
      send_rel(16'd300, 1'b1);
      send_rel(16'd2200, 1'b0);
      send_rel(16'd300, 1'b1);
      send_rel(16'd279, 1'b0);
      send_rel(16'd1800, 1'b1);
      send_rel(16'd280, 1'b0);
      send_rel(16'd1500, 1'b1);
      send_rel(16'd120, 1'b0);
      send_rel(16'd1800, 1'b1);
      send_rel(16'd2400, 1'b0);
      send_rel(16'd300, 1'b1);
      send_rel(16'd2000, 1'b0);
      send_rel(16'd300, 1'b1);
      send_rel(16'd2401, 1'b0);
      send_rel(16'd479, 1'b1);
      send_rel(16'd119, 1'b0);

      run_fields(150);

      settle();
      program_thresholds(jittered_thresholds());
      req_idle_pct = 59;
      rsp_idle_pct = 19;
      run_fields(150);

      settle();
      program_thresholds('0);
      run_noise(30);
      settle();
      program_thresholds('1);
      run_noise(30);
      settle();
      program_thresholds(corner_thresholds());
      run_noise(30);

      settle();
      program_thresholds(DEFAULT_THRESHOLDS);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // Stall the status side while edges keep coming.
      hold_pending = 1'b1;
      run_fields(100);
      long_haul();

      settle();
      repeat (8) @(posedge clock);

      $display("sent %0d sync edges in %0d structured fields over %0d threshold settings",
               edges_sent, fields_sent, settings_done);
      $display("compared %0d status transactions, %0d mismatches",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
